// File: src/hsj_pkg.sv
// Shared types, constants and helpers for the Jacobi heat stencil sweep.
package hsj_pkg;

	localparam int VALUE_W     = 32;
	localparam int MAX_COLS    = 1024;
	localparam int ADDR_W      = $clog2(MAX_COLS);
	localparam int COLS_W      = ADDR_W + 1;
	localparam int CNT_W       = 32;
	localparam int CNTX_W      = CNT_W + 1;
	localparam int ROWS_W      = 16;
	localparam int GRID_COLS_W = 11;
	localparam int FACTOR_W    = 15;
	localparam int SRC_COL_W   = 10;
	localparam int FRAC_W      = 16;
	localparam int LAP_W       = VALUE_W + 4;
	localparam int PROD_W      = LAP_W + FACTOR_W + 1;
	localparam int REG_IDX_W   = 3;
	localparam int PADDR_W     = REG_IDX_W + 2;
	localparam int PDATA_W     = 32;

	localparam logic CMD_CELL  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// input row counter saturates one below all ones
	localparam logic [CNT_W-1:0] IN_ROW_CAP = ~CNT_W'(1);

	// rounding half of one LSB in Q16.16
	localparam logic [FRAC_W-1:0] ROUND_HALF = {1'b1, {(FRAC_W-1){1'b0}}};

	localparam logic [ROWS_W-1:0]      GRID_ROWS_RST  = ROWS_W'(1000);
	localparam logic [GRID_COLS_W-1:0] GRID_COLS_RST  = GRID_COLS_W'(1000);
	localparam logic [FACTOR_W-1:0]    FACTOR_RST     = FACTOR_W'(5243);
	localparam logic [ROWS_W-1:0]      SRC_ROW_RST    = ROWS_W'(500);
	localparam logic [SRC_COL_W-1:0]   SRC_COL_RST    = SRC_COL_W'(500);
	localparam logic [VALUE_W-1:0]     SRC_VALUE_RST  = VALUE_W'(6553600);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GRID_ROWS    = 3'd0,
		REG_GRID_COLS    = 3'd1,
		REG_DIFF_FACTOR  = 3'd2,
		REG_SOURCE_ROW   = 3'd3,
		REG_SOURCE_COL   = 3'd4,
		REG_SOURCE_VALUE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic                      cmd;
		logic signed [VALUE_W-1:0] cell_value;
	} cell_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] new_value;
		logic                      frame_last;
	} result_item_t;

	typedef struct packed {
		logic interior;
		logic src_hit;
		logic last;
	} cell_flags_t;

	typedef struct packed {
		logic              emit;
		cell_flags_t       flags;
		logic [ADDR_W-1:0] addr;
	} s1_ctrl_t;

	function automatic logic signed [LAP_W-1:0] to_lap(input logic signed [VALUE_W-1:0] v);
		return {{(LAP_W-VALUE_W){v[VALUE_W-1]}}, v};
	endfunction

	function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [LAP_W-1:0] v);
		logic fits;
		fits = (&v[LAP_W-1:VALUE_W-1]) || !(|v[LAP_W-1:VALUE_W-1]);
		if (fits) begin
			return v[VALUE_W-1:0];
		end else if (v[LAP_W-1]) begin
			return {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(VALUE_W-1){1'b1}}};
		end
	endfunction

endpackage

// File: src/hsj_ram.sv
// Generic simple dual-port RAM with registered read.
module hsj_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/heat_stencil_jacobi_sweep.sv
// Top level: one Jacobi sweep of 2D heat diffusion, five-point stencil.
// Throughput: one transaction per cycle sustained while the output is not stalled;
//   line buffer RAMs are read once and written once per cell, on separate ports.
// Position: a result leaves the output register behind the input transaction
//   that completes its window (one row plus one cell behind the input stream).
// Reset: counters, window and pipeline valids clear, registers take their defaults;
//   line buffer RAMs are not cleared; the middle line holds garbage until a row has passed, the upper until two.
module heat_stencil_jacobi_sweep (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cell_valid,
	output logic                                cell_stall,
	input  hsj_pkg::cell_item_t                 cell_data,

	output logic                                result_valid,
	input  logic                                result_stall,
	output hsj_pkg::result_item_t               result_data,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [hsj_pkg::PADDR_W-1:0]         paddr,
	input  logic [hsj_pkg::PDATA_W-1:0]         pwdata,
	output logic [hsj_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);

	// ------------------------------------------------------------------
	// Configuration registers (APB, zero wait states)
	// ------------------------------------------------------------------
	logic [hsj_pkg::ROWS_W-1:0]       grid_rows_q;
	logic [hsj_pkg::GRID_COLS_W-1:0]  grid_cols_q;
	logic [hsj_pkg::FACTOR_W-1:0]     factor_q;
	logic [hsj_pkg::ROWS_W-1:0]       src_row_q;
	logic [hsj_pkg::SRC_COL_W-1:0]    src_col_q;
	logic signed [hsj_pkg::VALUE_W-1:0] src_val_q;

	hsj_pkg::reg_idx_t reg_idx;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = hsj_pkg::reg_idx_t'(paddr[hsj_pkg::PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= hsj_pkg::GRID_ROWS_RST;
			grid_cols_q <= hsj_pkg::GRID_COLS_RST;
			factor_q    <= hsj_pkg::FACTOR_RST;
			src_row_q   <= hsj_pkg::SRC_ROW_RST;
			src_col_q   <= hsj_pkg::SRC_COL_RST;
			src_val_q   <= hsj_pkg::SRC_VALUE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				hsj_pkg::REG_GRID_ROWS:    grid_rows_q <= pwdata[hsj_pkg::ROWS_W-1:0];
				hsj_pkg::REG_GRID_COLS:    grid_cols_q <= pwdata[hsj_pkg::GRID_COLS_W-1:0];
				hsj_pkg::REG_DIFF_FACTOR:  factor_q    <= pwdata[hsj_pkg::FACTOR_W-1:0];
				hsj_pkg::REG_SOURCE_ROW:   src_row_q   <= pwdata[hsj_pkg::ROWS_W-1:0];
				hsj_pkg::REG_SOURCE_COL:   src_col_q   <= pwdata[hsj_pkg::SRC_COL_W-1:0];
				hsj_pkg::REG_SOURCE_VALUE: src_val_q   <= pwdata[hsj_pkg::VALUE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			hsj_pkg::REG_GRID_ROWS:    prdata = hsj_pkg::PDATA_W'(grid_rows_q);
			hsj_pkg::REG_GRID_COLS:    prdata = hsj_pkg::PDATA_W'(grid_cols_q);
			hsj_pkg::REG_DIFF_FACTOR:  prdata = hsj_pkg::PDATA_W'(factor_q);
			hsj_pkg::REG_SOURCE_ROW:   prdata = hsj_pkg::PDATA_W'(src_row_q);
			hsj_pkg::REG_SOURCE_COL:   prdata = hsj_pkg::PDATA_W'(src_col_q);
			hsj_pkg::REG_SOURCE_VALUE: prdata = hsj_pkg::PDATA_W'(src_val_q);
			default:                   prdata = '0;
		endcase
	end

	// Effective geometry: at least 3x3, columns bounded by line buffer depth.
	logic [hsj_pkg::COLS_W-1:0] cols_eff;
	logic [hsj_pkg::ROWS_W-1:0] rows_eff;

	always_comb begin
		if (grid_cols_q < hsj_pkg::GRID_COLS_W'(3)) begin
			cols_eff = hsj_pkg::COLS_W'(3);
		end else if (hsj_pkg::CNT_W'(grid_cols_q) > hsj_pkg::CNT_W'(hsj_pkg::MAX_COLS)) begin
			cols_eff = hsj_pkg::COLS_W'(hsj_pkg::MAX_COLS);
		end else begin
			cols_eff = hsj_pkg::COLS_W'(grid_cols_q);
		end
		rows_eff = (grid_rows_q < hsj_pkg::ROWS_W'(3)) ? hsj_pkg::ROWS_W'(3) : grid_rows_q;
	end

	// ------------------------------------------------------------------
	// Elastic pipeline handshake. Each stage loads when it is empty or
	// when its occupant moves on, so bubbles collapse and the input keeps
	// flowing while a finished result waits in the output register.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic res_valid_q;
	logic en_out, ld3, ld2, ld1;
	logic accept;

	assign en_out     = !res_valid_q || !result_stall;
	assign ld3        = !v_s3 || en_out;
	assign ld2        = !v_s2 || ld3;
	assign ld1        = !v_s1 || ld2;
	assign cell_stall = !ld1;
	assign accept     = cell_valid && ld1;

	// ------------------------------------------------------------------
	// Stage 0: raster counters and per-cell control, decided at accept.
	// Input side counts pushed cells; output side counts emitted cells.
	// ------------------------------------------------------------------
	logic [hsj_pkg::ADDR_W-1:0] in_col_q, out_col_q;
	logic [hsj_pkg::CNT_W-1:0]  in_row_q, out_row_q;

	logic [hsj_pkg::ADDR_W-1:0] ic0, oc0, ic1;
	logic [hsj_pkg::CNT_W-1:0]  ir0, or0, ir1;
	logic [hsj_pkg::COLS_W-1:0] ic_inc, oc_p1;
	logic [hsj_pkg::CNTX_W-1:0] or_p1;
	logic                       ic_wrap;
	logic                       done, ignore, emit;
	hsj_pkg::cell_flags_t       flags_s0;

	logic [hsj_pkg::ADDR_W-1:0] ic_n, oc_n;
	logic [hsj_pkg::CNT_W-1:0]  ir_n, or_n;

	always_comb begin
		// counters left past a shrunken column bound wrap to the next row
		if (hsj_pkg::COLS_W'(in_col_q) >= cols_eff) begin
			ic0 = '0;
			ir0 = in_row_q + hsj_pkg::CNT_W'(1);
		end else begin
			ic0 = in_col_q;
			ir0 = in_row_q;
		end
		if (hsj_pkg::COLS_W'(out_col_q) >= cols_eff) begin
			oc0 = '0;
			or0 = out_row_q + hsj_pkg::CNT_W'(1);
		end else begin
			oc0 = out_col_q;
			or0 = out_row_q;
		end

		done   = ir0 >= hsj_pkg::CNT_W'(rows_eff);
		// early flush is dropped; a sample after the frame acts as a flush
		ignore = !done && (cell_data.cmd == hsj_pkg::CMD_FLUSH);

		if (ignore) begin
			emit = 1'b0;
		end else if (done) begin
			emit = or0 < hsj_pkg::CNT_W'(rows_eff);
		end else begin
			emit = (ir0 >= hsj_pkg::CNT_W'(2)) ||
			       ((ir0 == hsj_pkg::CNT_W'(1)) && (ic0 != '0));
		end

		ic_inc  = hsj_pkg::COLS_W'(ic0) + hsj_pkg::COLS_W'(1);
		ic_wrap = ic_inc >= cols_eff;
		ic1     = ic_wrap ? '0 : ic_inc[hsj_pkg::ADDR_W-1:0];
		ir1     = (ic_wrap && (ir0 < hsj_pkg::IN_ROW_CAP)) ? ir0 + hsj_pkg::CNT_W'(1) : ir0;

		or_p1 = hsj_pkg::CNTX_W'(or0) + hsj_pkg::CNTX_W'(1);
		oc_p1 = hsj_pkg::COLS_W'(oc0) + hsj_pkg::COLS_W'(1);

		flags_s0.interior = (or0 != '0) && (or_p1 < hsj_pkg::CNTX_W'(rows_eff)) &&
		                    (oc0 != '0) && (oc_p1 < cols_eff);
		flags_s0.src_hit  = (or0 == hsj_pkg::CNT_W'(src_row_q)) &&
		                    (hsj_pkg::CNT_W'(oc0) == hsj_pkg::CNT_W'(src_col_q));
		flags_s0.last     = (or_p1 >= hsj_pkg::CNTX_W'(rows_eff)) && (oc_p1 >= cols_eff);

		ic_n = ic0;
		ir_n = ir0;
		oc_n = oc0;
		or_n = or0;
		if (!ignore) begin
			ic_n = ic1;
			ir_n = ir1;
			if (emit) begin
				if (flags_s0.last) begin
					// end of frame: everything back to the origin
					ic_n = '0;
					ir_n = '0;
					oc_n = '0;
					or_n = '0;
				end else if (oc_p1 >= cols_eff) begin
					oc_n = '0;
					or_n = or0 + hsj_pkg::CNT_W'(1);
				end else begin
					oc_n = oc_p1[hsj_pkg::ADDR_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			in_col_q  <= ic_n;
			in_row_q  <= ir_n;
			out_col_q <= oc_n;
			out_row_q <= or_n;
		end
	end

	// ------------------------------------------------------------------
	// Line buffers. Read at accept, written back when the cell leaves
	// stage 1. Consecutive pushes always hit different columns (at least
	// three apart before a column repeats), so no forwarding is needed.
	// ------------------------------------------------------------------
	hsj_pkg::s1_ctrl_t                  ctl_s1;
	logic signed [hsj_pkg::VALUE_W-1:0] val_s1;
	logic [hsj_pkg::VALUE_W-1:0]        up_rd, mid_rd;
	logic                               mem_re, mem_we;

	assign mem_re = accept && !ignore;
	assign mem_we = v_s1 && ld2;

	// upper line takes the old middle entry; middle line takes the new cell
	hsj_ram #(
		.WIDTH (hsj_pkg::VALUE_W),
		.DEPTH (hsj_pkg::MAX_COLS)
	) u_upper_line (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ctl_s1.addr),
		.wdata (mid_rd),
		.re    (mem_re),
		.raddr (ic0),
		.rdata (up_rd)
	);

	hsj_ram #(
		.WIDTH (hsj_pkg::VALUE_W),
		.DEPTH (hsj_pkg::MAX_COLS)
	) u_middle_line (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ctl_s1.addr),
		.wdata (val_s1),
		.re    (mem_re),
		.raddr (ic0),
		.rdata (mid_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld1) begin
			v_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			ctl_s1.emit  <= emit;
			ctl_s1.flags <= flags_s0;
			ctl_s1.addr  <= ic0;
			val_s1       <= done ? '0 : cell_data.cell_value;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: window. Only the taps the stencil needs are kept: right
	// column top/bottom (w2, w8), centre column middle (w4), right middle
	// (w5). After the shift the centre is the old w5, the right middle is
	// the fresh middle-line read.
	// ------------------------------------------------------------------
	logic signed [hsj_pkg::VALUE_W-1:0] w2_q, w4_q, w5_q, w8_q;
	logic signed [hsj_pkg::LAP_W-1:0]   lap_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w2_q <= '0;
			w4_q <= '0;
			w5_q <= '0;
			w8_q <= '0;
		end else if (mem_we) begin
			w2_q <= up_rd;
			w4_q <= w5_q;
			w5_q <= mid_rd;
			w8_q <= val_s1;
		end
	end

	// up + down + left + right - 4*centre, exact
	assign lap_c = hsj_pkg::to_lap(w2_q) + hsj_pkg::to_lap(w8_q) + hsj_pkg::to_lap(w4_q) +
	               hsj_pkg::to_lap(mid_rd) - (hsj_pkg::to_lap(w5_q) <<< 2);

	// ------------------------------------------------------------------
	// Stage 2: Laplacian and centre registered; cells with no result drop out.
	// ------------------------------------------------------------------
	logic signed [hsj_pkg::LAP_W-1:0]   lap_s2;
	logic signed [hsj_pkg::VALUE_W-1:0] old_s2;
	hsj_pkg::cell_flags_t               flags_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld2) begin
			v_s2 <= v_s1 && ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			lap_s2   <= lap_c;
			old_s2   <= w5_q;
			flags_s2 <= ctl_s1.flags;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: one 36x16 signed multiply by the Q0.16 factor.
	// ------------------------------------------------------------------
	logic signed [hsj_pkg::PROD_W-1:0]  prod_s3;
	logic signed [hsj_pkg::VALUE_W-1:0] old_s3;
	hsj_pkg::cell_flags_t               flags_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ld3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			prod_s3  <= lap_s2 * $signed({1'b0, factor_q});
			old_s3   <= old_s2;
			flags_s3 <= flags_s2;
		end
	end

	// ------------------------------------------------------------------
	// Output: old*2^16 + half + product in one add, floor by 2^16,
	// saturate. Border cells pass through, the source cell is forced.
	// ------------------------------------------------------------------
	logic signed [hsj_pkg::PROD_W-1:0]  acc_c;
	logic signed [hsj_pkg::VALUE_W-1:0] upd_c, new_c;
	hsj_pkg::result_item_t              res_q;

	always_comb begin
		acc_c = prod_s3 + $signed({{(hsj_pkg::PROD_W-hsj_pkg::VALUE_W-hsj_pkg::FRAC_W)
		                             {old_s3[hsj_pkg::VALUE_W-1]}},
		                            old_s3, hsj_pkg::ROUND_HALF});
		upd_c = hsj_pkg::sat_value(acc_c[hsj_pkg::FRAC_W +: hsj_pkg::LAP_W]);
		if (flags_s3.src_hit) begin
			new_c = src_val_q;
		end else if (flags_s3.interior) begin
			new_c = upd_c;
		end else begin
			new_c = old_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en_out) begin
			res_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			res_q.new_value  <= new_c;
			res_q.frame_last <= flags_s3.last;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

endmodule

// File: src/hsj_checker.sv
// Port-level checker for the Jacobi heat stencil sweep, bound to the top level.
module hsj_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cell_valid,
	input  logic                        cell_stall,
	input  hsj_pkg::cell_item_t         cell_data,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  hsj_pkg::result_item_t       result_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hsj_pkg::PADDR_W-1:0] paddr,
	input  logic [hsj_pkg::PDATA_W-1:0] pwdata,
	input  logic [hsj_pkg::PDATA_W-1:0] prdata,
	input  logic                        pready
);

	logic src_val_sel;

	assign src_val_sel = paddr[hsj_pkg::PADDR_W-1:2] == hsj_pkg::REG_SOURCE_VALUE;

	// a stalled result transaction stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result_valid dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result_data))
		else $error("result_data changed while stalled");

	// with the output register empty the pipeline must take input
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !cell_stall)
		else $error("input stalled while no result is pending");

	// source value written then read back
	a_src_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && src_val_sel) ##1
		(psel && !pwrite && src_val_sel) |-> prdata == $past(pwdata))
		else $error("source_value readback mismatch");

endmodule

bind heat_stencil_jacobi_sweep hsj_checker u_hsj_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cell_valid   (cell_valid),
	.cell_stall   (cell_stall),
	.cell_data    (cell_data),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_data  (result_data),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata),
	.pready       (pready)
);
